### hdl/srtf_pkg.sv
// Shared constants and control types for the SRTF job scheduler.
// No dependencies; used by srtf_ctrl, srtf_dp and the top level.
`default_nettype none

package srtf_pkg;

  localparam int MAX_JOBS = 8;
  localparam int IDX_W    = $clog2(MAX_JOBS);
  localparam int SLOT_W   = 3;
  localparam int TIME_W   = 16;
  localparam int BURST_W  = 12;

  localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(MAX_JOBS - 1);
  localparam logic [BURST_W-1:0] BURST_MAX = BURST_W'(3200 - 1);
  localparam logic [TIME_W-1:0]  TIME_MAX  = '1;

  // item kinds carried on the input tuser
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic             load_we;     // write the loaded slot
    logic             scan_start;  // clear the running best before a scan
    logic             scan_en;     // compare slot idx against the best so far
    logic             commit;      // update state and load the result register
    logic [IDX_W-1:0] idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;  // result register empty or being taken this cycle
  } ctrl_sts_t;

endpackage

`default_nettype wire

### hdl/srtf_ctrl.sv
// Sequencer for the SRTF scheduler: accepts items, steps the slot scan,
// and commits the result. Depends on srtf_pkg.
`default_nettype none

module srtf_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_kind,
  output logic                     in_ready,
  input  wire srtf_pkg::ctrl_sts_t sts,
  output srtf_pkg::ctrl_cmd_t      cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0]                 state, state_next;
  logic [srtf_pkg::IDX_W-1:0] cnt, cnt_next;

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.idx        = cnt;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == srtf_pkg::KIND_LOAD) begin
            cmd.load_we = 1'b1;
          end else begin
            cmd.scan_start = 1'b1;
            cnt_next       = '0;
            state_next     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (cnt == srtf_pkg::LAST_IDX) begin
          state_next = ST_UPDATE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_UPDATE: begin
        // hold here while the previous result is still unclaimed
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

`default_nettype wire

### hdl/srtf_dp.sv
// Datapath for the SRTF scheduler: slot tables, time counter, one
// comparator for the serial scan, completion arithmetic and result register.
// Depends on srtf_pkg.
`default_nettype none

module srtf_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire srtf_pkg::ctrl_cmd_t           cmd,
  output srtf_pkg::ctrl_sts_t                sts,
  input  wire logic [srtf_pkg::SLOT_W-1:0]   ld_slot,
  input  wire logic [srtf_pkg::TIME_W-1:0]   ld_arrival,
  input  wire logic [srtf_pkg::BURST_W-1:0]  ld_burst,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_idle,
  output logic [srtf_pkg::SLOT_W-1:0]        out_job,
  output logic                               out_finished,
  output logic [srtf_pkg::TIME_W-1:0]        out_finish_time,
  output logic [srtf_pkg::TIME_W-1:0]        out_turnaround,
  output logic [srtf_pkg::TIME_W-1:0]        out_wait_time
);

  logic [srtf_pkg::BURST_W-1:0] remaining     [srtf_pkg::MAX_JOBS];
  logic [srtf_pkg::TIME_W-1:0]  arrival_store [srtf_pkg::MAX_JOBS];
  logic [srtf_pkg::BURST_W-1:0] burst_store   [srtf_pkg::MAX_JOBS];
  logic [srtf_pkg::TIME_W-1:0]  now;

  logic                         found;
  logic [srtf_pkg::IDX_W-1:0]   pick;
  logic [srtf_pkg::BURST_W-1:0] best_rem;
  logic [srtf_pkg::TIME_W-1:0]  best_arr;

  logic [srtf_pkg::IDX_W-1:0]   rd_addr;
  logic [srtf_pkg::BURST_W-1:0] rd_rem;
  logic [srtf_pkg::TIME_W-1:0]  rd_arr;
  logic [srtf_pkg::BURST_W-1:0] rd_bur;
  logic                         cand, better;

  logic                         ld_ok;
  logic [srtf_pkg::IDX_W-1:0]   ld_idx;
  logic [srtf_pkg::BURST_W-1:0] ld_bur_sat;

  logic [srtf_pkg::BURST_W-1:0] rem_dec;
  logic                         done;
  logic [srtf_pkg::TIME_W-1:0]  fin, turn, bur_ext, wait_val;

  // single read port: scan index while scanning, chosen slot afterwards
  assign rd_addr = cmd.scan_en ? cmd.idx : pick;
  assign rd_rem  = remaining[rd_addr];
  assign rd_arr  = arrival_store[rd_addr];
  assign rd_bur  = burst_store[rd_addr];

  assign cand   = (rd_rem != '0) && (rd_arr <= now);
  assign better = cand && (!found || (rd_rem < best_rem) ||
                           ((rd_rem == best_rem) && (rd_arr < best_arr)));

  assign ld_ok      = int'(ld_slot) < srtf_pkg::MAX_JOBS;
  assign ld_idx     = srtf_pkg::IDX_W'(ld_slot);
  assign ld_bur_sat = (ld_burst > srtf_pkg::BURST_MAX) ? srtf_pkg::BURST_MAX : ld_burst;

  assign rem_dec  = best_rem - 1'b1;
  assign done     = found && (rem_dec == '0);
  assign fin      = (now == srtf_pkg::TIME_MAX) ? now : now + 1'b1;
  assign turn     = fin - best_arr;
  assign bur_ext  = {{(srtf_pkg::TIME_W - srtf_pkg::BURST_W){1'b0}}, rd_bur};
  assign wait_val = (turn > bur_ext) ? turn - bur_ext : '0;

  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < srtf_pkg::MAX_JOBS; i++) begin
        remaining[i] <= '0;
      end
    end else if (cmd.load_we && ld_ok) begin
      remaining[ld_idx] <= ld_bur_sat;
    end else if (cmd.commit && found) begin
      remaining[pick] <= rem_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_we && ld_ok) begin
      arrival_store[ld_idx] <= ld_arrival;
      burst_store[ld_idx]   <= ld_bur_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now   <= '0;
      found <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        found <= 1'b0;
      end else if (cmd.scan_en && better) begin
        found <= 1'b1;
      end
      if (cmd.commit && (now != srtf_pkg::TIME_MAX)) begin
        now <= now + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_en && better) begin
      pick     <= cmd.idx;
      best_rem <= rd_rem;
      best_arr <= rd_arr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_idle        <= !found;
      out_job         <= found ? srtf_pkg::SLOT_W'(pick) : '0;
      out_finished    <= done;
      out_finish_time <= done ? fin : '0;
      out_turnaround  <= done ? turn : '0;
      out_wait_time   <= done ? wait_val : '0;
    end
  end

endmodule

`default_nettype wire

### hdl/srtf_job_scheduler_core.sv
// Top level of the SRTF job scheduler: stream ports, sequencer, datapath.
// Depends on srtf_pkg, srtf_ctrl and srtf_dp.
//
//   port group | dir | contents
//   s_axis     | in  | load a job slot (tuser = 0) or one time-slice tick (tuser = 1)
//   m_axis     | out | one result per tick, nothing for a load
//
// A load is written into its slot when it is accepted. A tick starts a scan:
// the slots are scanned one per cycle through a single comparator, then an
// update step updates the chosen slot and time; no item is taken meanwhile.
// Reset empties every slot and sets time to zero.
// The result sits in an output register; loads are still taken while it
// waits, a further tick holds in its update cycle until the result is taken.
`default_nettype none

module srtf_job_scheduler_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // slot[2:0], arrival[18:3], burst[30:19], zero
  input  wire logic        s_axis_tuser,   // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // job[2:0], finish_time[18:3],
                                           // turnaround[34:19], wait_time[50:35], zero
  output logic [1:0]       m_axis_tuser    // idle[0], finished[1]
);

  srtf_pkg::ctrl_cmd_t cmd;
  srtf_pkg::ctrl_sts_t sts;

  logic                          res_idle, res_finished;
  logic [srtf_pkg::SLOT_W-1:0]   res_job;
  logic [srtf_pkg::TIME_W-1:0]   res_fin, res_turn, res_wait;

  srtf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_kind  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  srtf_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .ld_slot         (s_axis_tdata[2:0]),
    .ld_arrival      (s_axis_tdata[18:3]),
    .ld_burst        (s_axis_tdata[30:19]),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_idle        (res_idle),
    .out_job         (res_job),
    .out_finished    (res_finished),
    .out_finish_time (res_fin),
    .out_turnaround  (res_turn),
    .out_wait_time   (res_wait)
  );

  assign m_axis_tdata = {5'b0, res_wait, res_turn, res_fin, res_job};
  assign m_axis_tuser = {res_finished, res_idle};

  // a commit never overwrites an unclaimed result
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result register overwritten");

  // an accepted tick starts a scan, so no item is taken on the next cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == srtf_pkg::KIND_TICK)
      |=> (!s_axis_tready && cmd.scan_en && cmd.idx == '0))
    else $error("tick did not start a scan");

  // a result only appears after a commit
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(cmd.commit))
    else $error("result without commit");

  // scanning excludes both accepting items and committing
  a_scan_excl: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_en |-> (!s_axis_tready && !cmd.commit))
    else $error("scan overlaps accept or commit");

endmodule

`default_nettype wire
